// File: design/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define C3RC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define C3RC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/c3rc_pkg.sv
// ============================================================================
// c3rc_pkg
// Constants and types of the 3x3 replicate-edge convolution block.
// ============================================================================
`default_nettype none

package c3rc_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int KSIZE      = 3;
    localparam int NTAPS      = KSIZE * KSIZE;

    localparam int PIX_W      = 8;
    localparam int COEF_W     = 8;
    localparam int DIM_W      = 11;
    localparam int KROW_W     = KSIZE * COEF_W;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int LINE_W     = 2 * PIX_W;
    localparam int WIN_IDX_W  = $clog2(NTAPS);

    localparam int PROD_W     = PIX_W + COEF_W + 1;
    localparam int ROW_SUM_W  = PROD_W + 1;
    localparam int SUM_W      = ROW_SUM_W + 2;
    localparam int PIX_MAX    = 255;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam int REG_IDX_W  = 3;
    localparam int ADDR_W     = REG_IDX_W + 2;
    localparam int DATA_W     = 32;

    localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KTOP   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KMID   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_KBOT   = 3'd4;

    localparam logic [DIM_W-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [DIM_W-1:0]  HEIGHT_RESET = 11'd1024;
    localparam logic [KROW_W-1:0] KROW_RESET   = 24'd65791;

    // Window position selected for a tap: oldest, middle, newest row/column.
    typedef logic [1:0] sel_t;
    localparam sel_t SEL_FAR  = 2'd0;
    localparam sel_t SEL_MID  = 2'd1;
    localparam sel_t SEL_NEAR = 2'd2;

    typedef logic [NTAPS-1:0][PIX_W-1:0]  tap_vec_t;
    typedef logic [KSIZE-1:0][KROW_W-1:0] kernel_t;

    typedef struct packed {
        logic valid;
        logic row_end;
        logic frame_end;
    } tag_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             row_end;
        logic             frame_end;
    } out_item_t;

endpackage

`default_nettype wire

// File: design/c3rc_in_if.sv
// ============================================================================
// c3rc_in_if
// Input pixel channel: valid/ready with request type and pixel.
// ============================================================================
`default_nettype none

interface c3rc_in_if;
    import c3rc_pkg::*;

    logic             valid;
    logic             ready;
    logic             req_type;
    logic [PIX_W-1:0] pixel_in;

    modport source (output valid, output req_type, output pixel_in, input ready);
    modport sink   (input valid, input req_type, input pixel_in, output ready);
endinterface

`default_nettype wire

// File: design/c3rc_out_if.sv
// ============================================================================
// c3rc_out_if
// Output pixel channel: valid/ready with pixel and row/frame end flags.
// ============================================================================
`default_nettype none

interface c3rc_out_if;
    import c3rc_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             row_end;
    logic             frame_end;

    modport source (output valid, output pixel_out, output row_end, output frame_end,
                    input ready);
    modport sink   (input valid, input pixel_out, input row_end, input frame_end,
                    output ready);
endinterface

`default_nettype wire

// File: design/c3rc_ram.sv
// ============================================================================
// c3rc_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module c3rc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: design/c3rc_mac.sv
// ============================================================================
// c3rc_mac
// Nine-tap multiply, row sums, total and clamp to 0..255; three stages.
// ============================================================================
`default_nettype none

module c3rc_mac (
    input  logic               clk,
    input  logic               rst_n,
    input  c3rc_pkg::tag_t     in_tag,
    input  c3rc_pkg::tap_vec_t in_taps,
    input  c3rc_pkg::kernel_t  kernel,
    output c3rc_pkg::tag_t     out_tag,
    output logic [c3rc_pkg::PIX_W-1:0] out_pixel
);
    import c3rc_pkg::*;

    logic signed [PROD_W-1:0]    prod_next [NTAPS];
    logic signed [PROD_W-1:0]    prod_reg  [NTAPS];
    logic signed [ROW_SUM_W-1:0] row_next  [KSIZE];
    logic signed [ROW_SUM_W-1:0] row_reg   [KSIZE];
    logic signed [SUM_W-1:0]     total;
    logic [PIX_W-1:0]            pixel_next;
    tag_t                        tag_a_reg;
    tag_t                        tag_b_reg;

    always_comb
    begin
        for (int i = 0; i < KSIZE; i++)
        begin
            for (int j = 0; j < KSIZE; j++)
            begin
                prod_next[i*KSIZE+j] =
                    PROD_W'(signed'({1'b0, in_taps[i*KSIZE+j]})) *
                    PROD_W'(signed'(kernel[i][j*COEF_W +: COEF_W]));
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < KSIZE; i++)
        begin
            row_next[i] = ROW_SUM_W'(prod_reg[i*KSIZE])
                        + ROW_SUM_W'(prod_reg[i*KSIZE+1])
                        + ROW_SUM_W'(prod_reg[i*KSIZE+2]);
        end
    end

    always_comb
    begin
        total = SUM_W'(row_reg[0]) + SUM_W'(row_reg[1]) + SUM_W'(row_reg[2]);
        if (total[SUM_W-1])
        begin
            pixel_next = '0;
        end
        else if (total > SUM_W'(PIX_MAX))
        begin
            pixel_next = PIX_W'(PIX_MAX);
        end
        else
        begin
            pixel_next = total[PIX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            out_tag   <= '0;
        end
        else
        begin
            tag_a_reg <= in_tag;
            tag_b_reg <= tag_a_reg;
            out_tag   <= tag_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        row_reg   <= row_next;
        out_pixel <= pixel_next;
    end

endmodule

`default_nettype wire

// File: design/conv3x3_replicate_clamp_top.sv
// ============================================================================
// conv3x3_replicate_clamp_top: streaming 3x3 convolution, replicated edges
// Path: a result passes the window, tap, MAC and output queue registers after
//   the item that completes its window (one row and one pixel after its position).
// Throughput: one item per cycle; the line-store RAM is read and written once
//   per item not dropped. Input ready drops while 8 results await output transfer.
// Reset: async active-low; registers to defaults, frame position, window and
//   output queue cleared. Line-store RAM is not cleared.
// ============================================================================
`default_nettype none
`include "assert_macros.svh"

module conv3x3_replicate_clamp_top (
    input  logic                          clk,
    input  logic                          rst_n,
    c3rc_in_if.sink                       pixels,
    c3rc_out_if.source                    results,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [c3rc_pkg::ADDR_W-1:0]   paddr,
    input  logic [c3rc_pkg::DATA_W-1:0]   pwdata,
    output logic [c3rc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import c3rc_pkg::*;

    // configuration
    logic [DIM_W-1:0]     width_reg;
    logic [DIM_W-1:0]     height_reg;
    kernel_t              kernel_reg;
    logic                 cfg_we;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic [DIM_W-1:0]     eff_w;
    logic [DIM_W-1:0]     eff_h;

    // input stage
    logic [COL_W-1:0]     col_reg;
    logic [COL_W-1:0]     col_next;
    logic [DIM_W-1:0]     row_reg;
    logic [DIM_W-1:0]     row_next;
    logic [DIM_W-1:0]     col_inc;
    logic                 acc;
    logic                 in_frame;
    logic                 live;
    logic                 x0;
    logic                 x1;
    logic                 w1;
    logic                 wrap;
    logic                 emit_s0;
    logic                 top_s0;
    logic                 bot_s0;
    logic                 frame_end_s0;
    logic [PIX_W-1:0]     pix_s0;
    sel_t                 rsel_s0 [KSIZE];
    sel_t                 csel_s0 [KSIZE];

    // line store and window stage
    logic                 s1_valid_reg;
    logic                 s1_emit_reg;
    logic                 s1_row_end_reg;
    logic                 s1_frame_end_reg;
    logic [COL_W-1:0]     s1_x_reg;
    logic [PIX_W-1:0]     s1_pix_reg;
    sel_t                 s1_rsel_reg [KSIZE];
    sel_t                 s1_csel_reg [KSIZE];
    logic                 s1_fwd_reg;
    logic                 s1_fwd_next;
    logic [LINE_W-1:0]    s1_fwd_data_reg;
    logic [LINE_W-1:0]    line_rd;
    logic [LINE_W-1:0]    line_cur;
    logic [LINE_W-1:0]    line_wr;
    logic [PIX_W-1:0]     top_s1;
    logic [PIX_W-1:0]     mid_s1;
    logic [PIX_W-1:0]     window_reg  [NTAPS];
    logic [PIX_W-1:0]     window_next [NTAPS];
    logic [PIX_W-1:0]     win_base    [NTAPS];
    tap_vec_t             tap_s1;

    // arithmetic stages
    tag_t                 s2_tag_reg;
    tap_vec_t             s2_tap_reg;
    tag_t                 mac_tag;
    logic [PIX_W-1:0]     mac_pixel;

    // output queue
    out_item_t            fifo_mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]     fifo_cnt_reg;
    logic [CNT_W-1:0]     fifo_cnt_next;
    logic [CNT_W-1:0]     pending_reg;
    logic [CNT_W-1:0]     pending_next;
    logic                 push;
    logic                 pop;

    // ------------------------------------------------------------------------
    // APB registers
    // ------------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign cfg_we  = psel && penable && pwrite;

    always_comb
    begin
        case (cfg_idx)
            REG_WIDTH:  prdata = DATA_W'(width_reg);
            REG_HEIGHT: prdata = DATA_W'(height_reg);
            REG_KTOP:   prdata = DATA_W'(kernel_reg[0]);
            REG_KMID:   prdata = DATA_W'(kernel_reg[1]);
            REG_KBOT:   prdata = DATA_W'(kernel_reg[2]);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            kernel_reg <= {KSIZE{KROW_RESET}};
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_WIDTH:  width_reg     <= pwdata[DIM_W-1:0];
                REG_HEIGHT: height_reg    <= pwdata[DIM_W-1:0];
                REG_KTOP:   kernel_reg[0] <= pwdata[KROW_W-1:0];
                REG_KMID:   kernel_reg[1] <= pwdata[KROW_W-1:0];
                REG_KBOT:   kernel_reg[2] <= pwdata[KROW_W-1:0];
                default:    ;
            endcase
        end
    end

    assign eff_w = (width_reg == '0) ? DIM_W'(1) :
                   (width_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_reg;
    assign eff_h = (height_reg == '0) ? DIM_W'(1) :
                   (height_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_reg;

    // ------------------------------------------------------------------------
    // Input stage: frame position, edge selection, line-store read
    // ------------------------------------------------------------------------
    assign pixels.ready = pending_reg < CNT_W'(FIFO_DEPTH);
    assign acc          = pixels.valid && pixels.ready;
    assign in_frame     = row_reg < eff_h;
    // drain inside the frame is dropped; past the last row every item drains
    assign live         = acc && !(in_frame && pixels.req_type);
    assign pix_s0       = in_frame ? pixels.pixel_in : '0;

    assign x0      = col_reg == '0;
    assign x1      = col_reg == COL_W'(1);
    assign w1      = eff_w == DIM_W'(1);
    assign emit_s0 = (row_reg >= DIM_W'(2)) || ((row_reg == DIM_W'(1)) && !x0);
    // at column zero the result is for the last column of the row before
    assign top_s0  = x0 ? (row_reg == DIM_W'(2)) : (row_reg == DIM_W'(1));
    assign bot_s0  = x0 ? (row_reg == DIM_W'(eff_h + DIM_W'(1))) : (row_reg == eff_h);
    assign frame_end_s0 = emit_s0 && x0 && bot_s0;

    always_comb
    begin
        rsel_s0[0] = bot_s0 ? SEL_MID : SEL_NEAR;
        rsel_s0[1] = SEL_MID;
        rsel_s0[2] = top_s0 ? SEL_MID : SEL_FAR;
        csel_s0[0] = SEL_NEAR;
        csel_s0[1] = x0 ? SEL_NEAR : SEL_MID;
        if (x0)
        begin
            csel_s0[2] = w1 ? SEL_NEAR : SEL_MID;
        end
        else
        begin
            csel_s0[2] = x1 ? SEL_MID : SEL_FAR;
        end
    end

    always_comb
    begin
        col_inc  = DIM_W'(col_reg) + DIM_W'(1);
        wrap     = col_inc == eff_w;
        col_next = wrap ? '0 : col_inc[COL_W-1:0];
        row_next = wrap ? row_reg + DIM_W'(1) : row_reg;
        if (frame_end_s0)
        begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_we && ((cfg_idx == REG_WIDTH) || (cfg_idx == REG_HEIGHT)))
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (live)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------------
    // Line store: {older row, previous row} per column
    // ------------------------------------------------------------------------
    c3rc_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_x_reg),
        .wdata (line_wr),
        .re    (live),
        .raddr (col_reg),
        .rdata (line_rd)
    );

    // same column back to back (single-pixel rows): take the pending write
    assign s1_fwd_next = s1_valid_reg && (s1_x_reg == col_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= live;
        end
    end

    always_ff @(posedge clk)
    begin
        if (live)
        begin
            s1_emit_reg      <= emit_s0;
            s1_row_end_reg   <= x0;
            s1_frame_end_reg <= frame_end_s0;
            s1_x_reg         <= col_reg;
            s1_pix_reg       <= pix_s0;
            s1_rsel_reg      <= rsel_s0;
            s1_csel_reg      <= csel_s0;
            s1_fwd_reg       <= s1_fwd_next;
            s1_fwd_data_reg  <= line_wr;
        end
    end

    assign line_cur = s1_fwd_reg ? s1_fwd_data_reg : line_rd;
    assign top_s1   = line_cur[LINE_W-1:PIX_W];
    assign mid_s1   = line_cur[PIX_W-1:0];
    assign line_wr  = {mid_s1, s1_pix_reg};

    // ------------------------------------------------------------------------
    // Window shift and tap selection
    // ------------------------------------------------------------------------
    always_comb
    begin
        for (int k = 0; k < KSIZE; k++)
        begin
            for (int m = 0; m < KSIZE - 1; m++)
            begin
                window_next[k*KSIZE+m] = window_reg[k*KSIZE+m+1];
            end
        end
        window_next[KSIZE-1]         = top_s1;
        window_next[2*KSIZE-1]       = mid_s1;
        window_next[KSIZE*KSIZE-1]   = s1_pix_reg;
    end

    always_comb
    begin
        logic [WIN_IDX_W-1:0] idx;
        idx = '0;
        for (int k = 0; k < NTAPS; k++)
        begin
            win_base[k] = s1_row_end_reg ? window_reg[k] : window_next[k];
        end
        for (int i = 0; i < KSIZE; i++)
        begin
            for (int j = 0; j < KSIZE; j++)
            begin
                idx = WIN_IDX_W'(s1_rsel_reg[i]) * WIN_IDX_W'(KSIZE)
                    + WIN_IDX_W'(s1_csel_reg[j]);
                tap_s1[i*KSIZE+j] = win_base[idx];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NTAPS; k++)
            begin
                window_reg[k] <= '0;
            end
            s2_tag_reg <= '0;
        end
        else
        begin
            if (s1_valid_reg)
            begin
                window_reg <= window_next;
            end
            s2_tag_reg.valid     <= s1_valid_reg && s1_emit_reg;
            s2_tag_reg.row_end   <= s1_row_end_reg;
            s2_tag_reg.frame_end <= s1_frame_end_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_tap_reg <= tap_s1;
    end

    c3rc_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tag    (s2_tag_reg),
        .in_taps   (s2_tap_reg),
        .kernel    (kernel_reg),
        .out_tag   (mac_tag),
        .out_pixel (mac_pixel)
    );

    // ------------------------------------------------------------------------
    // Output queue with credit on results in flight
    // ------------------------------------------------------------------------
    assign push = mac_tag.valid;
    assign pop  = results.valid && results.ready;

    assign fifo_cnt_next = fifo_cnt_reg + CNT_W'(push) - CNT_W'(pop);
    assign pending_next  = pending_reg + CNT_W'(live && emit_s0) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            pending_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            fifo_cnt_reg <= fifo_cnt_next;
            pending_reg  <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem_reg[wr_ptr_reg] <= '{pixel_out: mac_pixel,
                                          row_end:   mac_tag.row_end,
                                          frame_end: mac_tag.frame_end};
        end
    end

    assign results.valid     = fifo_cnt_reg != '0;
    assign results.pixel_out = fifo_mem_reg[rd_ptr_reg].pixel_out;
    assign results.row_end   = fifo_mem_reg[rd_ptr_reg].row_end;
    assign results.frame_end = fifo_mem_reg[rd_ptr_reg].frame_end;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `C3RC_ASSERT_SAME(a_queue_within_credit, 1'b1, fifo_cnt_reg <= pending_reg,
                      "output queue holds more results than were credited")
    `C3RC_ASSERT_SAME(a_no_queue_overflow, push,
                      (fifo_cnt_reg < CNT_W'(FIFO_DEPTH)) || pop,
                      "result pushed into a full output queue")
    `C3RC_ASSERT_NEXT(a_frame_restart, live && frame_end_s0 && !cfg_we,
                      (col_reg == '0) && (row_reg == '0),
                      "frame position not cleared after last result")

endmodule

`default_nettype wire

// File: dv/conv3x3_replicate_clamp_top_test.sv
`timescale 1ns / 100ps
// ============================================================================
// conv3x3_replicate_clamp_top_test
// Self-checking testbench of the 3x3 replicate-edge convolution. Pixel and
// drain transfers are driven from a queue, a bit-accurate predictor of the
// line stores, window and frame position forms the expected pixel stream, and
// every output transfer is checked against it. Frames of many sizes and
// kernels are run, with random idling on both channels.
// ============================================================================
module conv3x3_replicate_clamp_top_test;
    import c3rc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 24;
    localparam int RANDOM_ITEMS   = 500;
    localparam int WIDE_ROW       = 130;
    localparam int TALL_COL       = 130;
    localparam int MAX_REPORTS    = 10;
    localparam int NOISE_PCT      = 5;

    localparam logic [PIX_W-1:0] DIRECTED_PIXELS [12] = '{
        8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE,
        8'h10, 8'h20, 8'h40, 8'h55, 8'hAA, 8'h08
    };

    typedef struct packed {
        logic             drain;
        logic [PIX_W-1:0] pixel;
    } stream_item_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    c3rc_in_if  pixels_if ();
    c3rc_out_if results_if ();

    conv3x3_replicate_clamp_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pixels_if),
        .results (results_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // register mirror
    logic [DIM_W-1:0]  cfg_width;
    logic [DIM_W-1:0]  cfg_height;
    logic [KROW_W-1:0] cfg_kernel [KSIZE];

    // predictor state
    logic [PIX_W-1:0] line_older [MAX_WIDTH];
    logic [PIX_W-1:0] line_newer [MAX_WIDTH];
    logic [PIX_W-1:0] window_taps [NTAPS];
    int               in_col;
    int               in_row;
    int               out_pos;

    stream_item_t feed_q [$];
    out_item_t    expected_pixels [$];
    stream_item_t next_item;
    out_item_t    want;

    logic in_taken;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   err_count;
    int   items_queued;
    int   items_accepted;
    int   results_checked;
    int   frames_done;
    int   drains_ignored;
    int   cfg_writes;
    int   idle_cycles;

    function automatic int clip(int v, int lo, int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int dim_used(logic [DIM_W-1:0] v, int limit);
        if (v == 0)
            return 1;
        if (int'(v) > limit)
            return limit;
        return int'(v);
    endfunction

    function automatic int coef(int i, int j);
        return int'($signed(cfg_kernel[i][COEF_W*j +: COEF_W]));
    endfunction

    function automatic void restart_position();
        in_col  = 0;
        in_row  = 0;
        out_pos = 0;
    endfunction

    // bottom window row holds image row wr, right column holds column wc
    function automatic logic [PIX_W-1:0] conv_value(int r, int c, int wr, int wc);
        int w;
        int h;
        int acc;
        int ri;
        int ci;
        w   = dim_used(cfg_width, MAX_WIDTH);
        h   = dim_used(cfg_height, MAX_HEIGHT);
        acc = 0;
        for (int i = 0; i < KSIZE; i++)
        begin
            ri = clip(clip(r + 1 - i, 0, h - 1) - wr + 2, 0, 2);
            for (int j = 0; j < KSIZE; j++)
            begin
                ci = clip(clip(c + 1 - j, 0, w - 1) - wc + 2, 0, 2);
                acc += int'(window_taps[ri * KSIZE + ci]) * coef(i, j);
            end
        end
        return PIX_W'(clip(acc, 0, PIX_MAX));
    endfunction

    function automatic void shift_window(int x, logic [PIX_W-1:0] pix);
        int               a;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] mid;
        a  = x % MAX_WIDTH;
        up = line_older[a];
        mid = line_newer[a];
        line_older[a] = mid;
        line_newer[a] = pix;
        for (int k = 0; k < KSIZE; k++)
        begin
            window_taps[k * KSIZE]     = window_taps[k * KSIZE + 1];
            window_taps[k * KSIZE + 1] = window_taps[k * KSIZE + 2];
        end
        window_taps[2] = up;
        window_taps[5] = mid;
        window_taps[8] = pix;
    endfunction

    task automatic conv_predict(logic drain, logic [PIX_W-1:0] pix_in);
        int               w;
        int               h;
        int               y;
        int               x;
        int               total;
        int               c;
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] value;
        logic             emit;
        w     = dim_used(cfg_width, MAX_WIDTH);
        h     = dim_used(cfg_height, MAX_HEIGHT);
        total = w * h;
        pix   = pix_in;
        value = '0;
        c     = 0;
        if (in_col >= w)
        begin
            in_col = 0;
            in_row++;
        end
        y = in_row;
        x = in_col;
        if (y < h)
        begin
            if (drain)
            begin
                drains_ignored++;
                return;
            end
        end
        else
            pix = '0;
        emit = (y * w + x >= w + 1) && (out_pos < total);
        if (x == 0)
        begin
            if (emit)
            begin
                c     = w - 1;
                value = conv_value(y - 2, c, y - 1, w - 1);
            end
            shift_window(x, pix);
        end
        else
        begin
            shift_window(x, pix);
            if (emit)
            begin
                c     = x - 1;
                value = conv_value(y - 1, c, y, x);
            end
        end
        in_col++;
        if (in_col >= w)
        begin
            in_col = 0;
            in_row = (in_row + 1) & 'h7FF;
        end
        if (emit)
        begin
            expected_pixels.push_back('{pixel_out: value, row_end: (c == w - 1),
                                        frame_end: (out_pos == total - 1)});
            out_pos++;
            if (out_pos >= total)
                restart_position();
        end
    endtask

    task automatic report_error(string what);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $time, what);
    endtask

    function automatic logic [DATA_W-1:0] junk_above(int bits, logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] j;
        j = $urandom;
        return (j & ~((DATA_W'(1) << bits) - 1)) | v;
    endfunction

    function automatic logic [DATA_W-1:0] reg_value(logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_WIDTH:  return DATA_W'(cfg_width);
            REG_HEIGHT: return DATA_W'(cfg_height);
            REG_KTOP:   return DATA_W'(cfg_kernel[0]);
            REG_KMID:   return DATA_W'(cfg_kernel[1]);
            REG_KBOT:   return DATA_W'(cfg_kernel[2]);
            default:    return '0;
        endcase
    endfunction

    task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        pwdata  = $urandom;
        cfg_writes++;
        case (idx)
            REG_WIDTH:
            begin
                cfg_width = value[DIM_W-1:0];
                restart_position();
            end
            REG_HEIGHT:
            begin
                cfg_height = value[DIM_W-1:0];
                restart_position();
            end
            REG_KTOP: cfg_kernel[0] = value[KROW_W-1:0];
            REG_KMID: cfg_kernel[1] = value[KROW_W-1:0];
            REG_KBOT: cfg_kernel[2] = value[KROW_W-1:0];
            default: ;
        endcase
    endtask

    task automatic reg_check(logic [REG_IDX_W-1:0] idx);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (prdata !== reg_value(idx))
            report_error($sformatf("register %0d read: expected 0x%0h, got 0x%0h",
                                   idx, reg_value(idx), prdata));
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic wait_for_quiet();
        while (items_accepted != items_queued || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_frame(logic [DIM_W-1:0] wv, logic [DIM_W-1:0] hv);
        wait_for_quiet();
        reg_write(REG_WIDTH, junk_above(DIM_W, DATA_W'(wv)));
        reg_write(REG_HEIGHT, junk_above(DIM_W, DATA_W'(hv)));
    endtask

    task automatic write_kernel(logic [KROW_W-1:0] top, logic [KROW_W-1:0] mid,
                                logic [KROW_W-1:0] bot);
        reg_write(REG_KTOP, junk_above(KROW_W, DATA_W'(top)));
        reg_write(REG_KMID, junk_above(KROW_W, DATA_W'(mid)));
        reg_write(REG_KBOT, junk_above(KROW_W, DATA_W'(bot)));
        for (int r = REG_WIDTH; r <= REG_KBOT; r++)
            reg_check(REG_IDX_W'(r));
    endtask

    function automatic logic [KROW_W-1:0] rand_kernel_row();
        logic [KROW_W-1:0] row;
        int                style;
        style = $urandom_range(3);
        for (int j = 0; j < KSIZE; j++)
        begin
            case (style)
                0, 1:    row[COEF_W*j +: COEF_W] = COEF_W'($urandom_range(6)) - 8'd3;
                2:       row[COEF_W*j +: COEF_W] = COEF_W'($urandom);
                default: row[COEF_W*j +: COEF_W] = $urandom_range(1) ? 8'h80 : 8'h7F;
            endcase
        end
        return row;
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim(int top);
        case ($urandom_range(9))
            0:       return '0;
            1:       return DIM_W'(1);
            default: return DIM_W'($urandom_range(2, top));
        endcase
    endfunction

    task automatic push_item(logic drain, logic [PIX_W-1:0] pix);
        feed_q.push_back('{drain: drain, pixel: pix});
        items_queued++;
    endtask

    // pixels of a frame with stray drains mixed in, then the flush transfers
    task automatic queue_frame(int npix, int nflush, int noise_pct, output int counted);
        for (int n = 0; n < npix; n++)
        begin
            if ($urandom_range(99) < noise_pct)
                push_item(1'b1, PIX_W'($urandom));
            push_item(1'b0, rand_pixel());
        end
        for (int n = 0; n < nflush; n++)
            push_item($urandom_range(3) != 0, PIX_W'($urandom));
        counted = npix + nflush;
    endtask

    task automatic set_idle(int mode);
        case (mode)
            0:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct  = 58;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 58;
            end
            default:
            begin
                send_idle_pct  = 21;
                recv_stall_pct = 21;
            end
        endcase
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!pixels_if.valid || in_taken)
            begin
                if (feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_item = feed_q.pop_front();
                    pixels_if.valid    <= 1'b1;
                    pixels_if.req_type <= next_item.drain;
                    pixels_if.pixel_in <= next_item.pixel;
                end
                else
                begin
                    pixels_if.valid    <= 1'b0;
                    pixels_if.req_type <= 1'($urandom);
                    pixels_if.pixel_in <= PIX_W'($urandom);
                end
            end
            results_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor, checker and watchdog
    always @(posedge clk)
    begin
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            in_taken <= pixels_if.valid && pixels_if.ready;
            if (pixels_if.valid && pixels_if.ready)
            begin
                items_accepted++;
                conv_predict(pixels_if.req_type, pixels_if.pixel_in);
            end
            if (results_if.valid && results_if.ready)
            begin
                if (expected_pixels.size() == 0)
                    report_error($sformatf("unexpected result pixel=%0d row_end=%0b frame_end=%0b",
                                           results_if.pixel_out, results_if.row_end,
                                           results_if.frame_end));
                else
                begin
                    want = expected_pixels.pop_front();
                    if (want.pixel_out !== results_if.pixel_out ||
                        want.row_end !== results_if.row_end ||
                        want.frame_end !== results_if.frame_end)
                        report_error($sformatf(
                            "result %0d: expected pixel=%0d row_end=%0b frame_end=%0b, got %0d %0b %0b",
                            results_checked, want.pixel_out, want.row_end, want.frame_end,
                            results_if.pixel_out, results_if.row_end, results_if.frame_end));
                    results_checked++;
                    if (want.frame_end)
                        frames_done++;
                end
            end
            if ((pixels_if.valid && pixels_if.ready) || (results_if.valid && results_if.ready))
                idle_cycles = 0;
            else if (items_accepted != items_queued || expected_pixels.size() != 0)
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("tb: failure");
                    $finish;
                end
            end
            else
                idle_cycles = 0;
        end
    end

    initial
    begin
        int               budget;
        int               n_frame;
        int               counted;
        int               wu;
        int               hu;
        logic [DIM_W-1:0] wv;
        logic [DIM_W-1:0] hv;

        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        pixels_if.valid    = 1'b0;
        pixels_if.req_type = 1'b0;
        pixels_if.pixel_in = '0;
        results_if.ready   = 1'b0;
        err_count       = 0;
        items_queued    = 0;
        items_accepted  = 0;
        results_checked = 0;
        frames_done     = 0;
        drains_ignored  = 0;
        cfg_writes      = 0;
        idle_cycles     = 0;
        cfg_width  = WIDTH_RESET;
        cfg_height = HEIGHT_RESET;
        for (int k = 0; k < KSIZE; k++)
            cfg_kernel[k] = KROW_RESET;
        for (int a = 0; a < MAX_WIDTH; a++)
        begin
            line_older[a] = '0;
            line_newer[a] = '0;
        end
        for (int t = 0; t < NTAPS; t++)
            window_taps[t] = '0;
        restart_position();
        set_idle(0);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int r = REG_WIDTH; r <= REG_KBOT; r++)
            reg_check(REG_IDX_W'(r));

        // directed: 4x3 frame, kernel picks the pixel one row down and one column right
        program_frame(DIM_W'(4), DIM_W'(3));
        write_kernel(24'h000001, 24'h000000, 24'h000000);
        for (int n = 0; n < 12; n++)
        begin
            if (n == 5)
                push_item(1'b1, 8'h33);
            push_item(1'b0, DIRECTED_PIXELS[n]);
        end
        push_item(1'b1, 8'h00);
        push_item(1'b0, 8'hC8);
        push_item(1'b1, 8'hFF);
        push_item(1'b0, 8'h11);
        push_item(1'b1, 8'h00);

        // directed: zero sizes act as 1x1, extreme coefficients
        program_frame('0, '0);
        write_kernel(24'h7F807F, 24'h807F80, 24'h7F807F);
        push_item(1'b0, 8'hFF);
        push_item(1'b1, 8'h5A);
        push_item(1'b0, 8'h00);

        // wide single row, then tall single column
        set_idle(3);
        program_frame(DIM_W'(WIDE_ROW), '0);
        write_kernel(rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
        queue_frame(WIDE_ROW, WIDE_ROW + 1, 0, counted);
        set_idle(1);
        program_frame('0, DIM_W'(TALL_COL));
        queue_frame(TALL_COL, 2, NOISE_PCT, counted);

        budget  = 0;
        n_frame = 0;
        while (budget < RANDOM_ITEMS)
        begin
            if (n_frame == 0 || $urandom_range(3) != 0)
            begin
                wv = pick_dim(12);
                hv = pick_dim(8);
                program_frame(wv, hv);
                if (n_frame == 0 || $urandom_range(1) != 0)
                    write_kernel(rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
            end
            set_idle(n_frame % 4);
            wu = dim_used(cfg_width, MAX_WIDTH);
            hu = dim_used(cfg_height, MAX_HEIGHT);
            if ($urandom_range(7) == 0)
                queue_frame($urandom_range(1, wu * hu), $urandom_range(wu + 1), NOISE_PCT,
                            counted);
            else
                queue_frame(wu * hu, wu + 1, NOISE_PCT, counted);
            budget += counted;
            n_frame++;
        end

        wait_for_quiet();
        $display("summary: %0d transfers in (%0d drains ignored), %0d results checked, %0d frames",
                 items_accepted, drains_ignored, results_checked, frames_done);
        $display("summary: %0d register writes, sizes from 1 up to %0d, four idle mixes",
                 cfg_writes, WIDE_ROW);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
